>>> src/msfw_pkg.sv
// ----------------------------------------------------------------------------
// msfw_pkg
// shared types and constants for the minimum spanning forest weight block
// ----------------------------------------------------------------------------
package msfw_pkg;

  localparam int NODE_W   = 10;
  localparam int WEIGHT_W = 16;
  localparam int TOTAL_W  = 26;
  localparam int NCNT_W   = 11;
  localparam int NODE_NUM = 1024;

  localparam logic [NCNT_W-1:0] NODE_LIMIT = NCNT_W'(NODE_NUM);

  typedef struct packed {
    logic        [NODE_W-1:0]   node_a;
    logic        [NODE_W-1:0]   node_b;
    logic signed [WEIGHT_W-1:0] edge_weight;
    logic                       last_edge;
  } in_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_weight;
    logic                      bad_input;
  } out_t;

  typedef struct packed {
    logic        [NODE_W-1:0]   node_a;
    logic        [NODE_W-1:0]   node_b;
    logic signed [WEIGHT_W-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic load_en;
    logic par_clr;
    logic sort_init;
    logic merge_wr;
    logic kr_mode;
    logic edge_latch;
    logic find_step;
    logic find_b;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic sort_skip;
    logic sort_done;
    logic kr_done;
    logic is_root;
    logic out_free;
  } sts_t;

  typedef enum logic [9:0] {
    S_LOAD       = 10'b0000000001,
    S_PAR_CLR    = 10'b0000000010,
    S_SORT_START = 10'b0000000100,
    S_MRG_RD     = 10'b0000001000,
    S_MRG_WR     = 10'b0000010000,
    S_KR_RD      = 10'b0000100000,
    S_KR_EDGE    = 10'b0001000000,
    S_FIND_RD    = 10'b0010000000,
    S_FIND_CHK   = 10'b0100000000,
    S_RESULT     = 10'b1000000000
  } state_t;

endpackage

>>> src/msfw_ctrl.sv
// ----------------------------------------------------------------------------
// msfw_ctrl
// sequencer for edge loading, merge sort passes, union-find walk and result
// ----------------------------------------------------------------------------
module msfw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_stall,
  output msfw_pkg::cmd_t cmd,
  input  msfw_pkg::sts_t sts
);
  import msfw_pkg::*;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    phase_nxt = phase_r;
    case (state_r)
      S_LOAD: begin
        cmd.load_en = in_valid;
        if (in_valid && in_last) state_nxt = S_PAR_CLR;
      end
      S_PAR_CLR: begin
        cmd.par_clr = 1'b1;
        if (sts.clr_done) state_nxt = S_SORT_START;
      end
      S_SORT_START: begin
        cmd.sort_init = 1'b1;
        state_nxt     = sts.sort_skip ? S_KR_RD : S_MRG_RD;
      end
      S_MRG_RD: begin
        state_nxt = S_MRG_WR;
      end
      S_MRG_WR: begin
        cmd.merge_wr = 1'b1;
        state_nxt    = sts.sort_done ? S_KR_RD : S_MRG_RD;
      end
      S_KR_RD: begin
        cmd.kr_mode = 1'b1;
        state_nxt   = sts.kr_done ? S_RESULT : S_KR_EDGE;
      end
      S_KR_EDGE: begin
        cmd.edge_latch = 1'b1;
        phase_nxt      = 1'b0;
        state_nxt      = S_FIND_RD;
      end
      S_FIND_RD: begin
        state_nxt = S_FIND_CHK;
      end
      S_FIND_CHK: begin
        cmd.find_step = 1'b1;
        cmd.find_b    = phase_r;
        if (!sts.is_root) begin
          state_nxt = S_FIND_RD;
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_FIND_RD;
        end else begin
          state_nxt = S_KR_RD;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_nxt  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule

>>> src/msfw_dp.sv
// ----------------------------------------------------------------------------
// msfw_dp
// edge stores, merge pointers, parent table, weight accumulator, output reg
// ----------------------------------------------------------------------------
module msfw_dp #(
  parameter int MAX_EDGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  msfw_pkg::in_t                in_data,
  input  logic                         cfg_valid,
  input  logic [msfw_pkg::NCNT_W-1:0]  cfg_node_count,
  input  msfw_pkg::cmd_t               cmd,
  output msfw_pkg::sts_t               sts,
  input  logic                         out_stall,
  output logic                         out_valid,
  output msfw_pkg::out_t               out_data
);
  import msfw_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LW = $clog2(MAX_EDGES + 1);
  localparam int CW = $clog2(MAX_EDGES) + 3;

  function automatic logic [CW-1:0] cmin(input logic [CW-1:0] x, input logic [CW-1:0] y);
    cmin = (x < y) ? x : y;
  endfunction

  edge_t mem_a [MAX_EDGES];
  edge_t mem_b [MAX_EDGES];
  edge_t a0_r, a1_r, b0_r, b1_r;

  logic [NODE_W-1:0] parent_mem [NODE_NUM];
  logic [NODE_W-1:0] pdata_r, paddr_r;
  logic [NODE_W-1:0] clr_r;

  logic [NCNT_W-1:0] ncnt_r;
  logic [LW-1:0]     loaded_r, i_r;
  logic              err_r;
  logic [CW-1:0]     width_r, l_r, le_r, r_r, re_r, k_r;
  logic              src_sel_r;
  edge_t             edge_r;
  logic [NODE_W-1:0] x_r, ra_r;
  logic signed [TOTAL_W-1:0] sum_r;
  logic              out_valid_r;
  out_t              out_data_r;

  logic [NCNT_W-1:0] lim;
  logic              bad, full, load_wr;
  logic [CW-1:0]     n_c, width2;
  logic [CW-1:0]     le_init, re_init, le_run, re_run, le_pass, re_pass, l_s, r_s;
  logic              take_l, run_end, pass_end;
  edge_t             src0, src1, wr_data;
  logic [AW-1:0]     wr_addr, rd0_addr, rd1_addr;
  logic              wr_a_en, wr_b_en;
  logic [NODE_W-1:0] par;
  logic              is_root;

  assign lim  = (ncnt_r > NODE_LIMIT) ? NODE_LIMIT : ncnt_r;
  assign bad  = ({1'b0, in_data.node_a} >= lim) || ({1'b0, in_data.node_b} >= lim);
  assign full = (loaded_r == LW'(MAX_EDGES));
  assign load_wr = cmd.load_en && !bad && !full;

  assign n_c     = CW'(loaded_r);
  assign width2  = width_r << 1;
  assign src0    = src_sel_r ? b0_r : a0_r;
  assign src1    = src_sel_r ? b1_r : a1_r;
  assign take_l  = (l_r < le_r) && ((r_r >= re_r) || (src0.weight <= src1.weight));
  assign l_s     = l_r + CW'(take_l);
  assign r_s     = r_r + CW'(!take_l);
  assign run_end = (l_s == le_r) && (r_s == re_r);
  assign pass_end = run_end && (re_r == n_c);
  assign le_init = cmin(CW'(1), n_c);
  assign re_init = cmin(le_init + CW'(1), n_c);
  assign le_run  = cmin(re_r + width_r, n_c);
  assign re_run  = cmin(le_run + width_r, n_c);
  assign le_pass = cmin(width2, n_c);
  assign re_pass = cmin(le_pass + width2, n_c);
  assign wr_data = take_l ? src0 : src1;

  assign wr_addr  = cmd.load_en ? loaded_r[AW-1:0] : k_r[AW-1:0];
  assign wr_a_en  = load_wr || (cmd.merge_wr && src_sel_r);
  assign wr_b_en  = cmd.merge_wr && !src_sel_r;
  assign rd0_addr = cmd.kr_mode ? i_r[AW-1:0] : l_r[AW-1:0];
  assign rd1_addr = r_r[AW-1:0];

  assign par     = pdata_r;
  assign is_root = (par == paddr_r);

  assign sts.clr_done  = (clr_r == NODE_W'(NODE_NUM - 1));
  assign sts.sort_skip = (n_c <= CW'(1));
  assign sts.sort_done = pass_end && (width2 >= n_c);
  assign sts.kr_done   = (i_r == loaded_r);
  assign sts.is_root   = is_root;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // edge stores
  always_ff @(posedge clk) begin
    if (wr_a_en) begin
      mem_a[wr_addr] <= cmd.load_en ?
        edge_t'{in_data.node_a, in_data.node_b, in_data.edge_weight} : wr_data;
    end
    if (wr_b_en) mem_b[wr_addr] <= wr_data;
    a0_r <= mem_a[rd0_addr];
    a1_r <= mem_a[rd1_addr];
    b0_r <= mem_b[rd0_addr];
    b1_r <= mem_b[rd1_addr];
  end

  // parent table
  always_ff @(posedge clk) begin
    pdata_r <= parent_mem[x_r];
    paddr_r <= x_r;
    if (cmd.par_clr) begin
      parent_mem[clr_r] <= clr_r;
    end else if (cmd.find_step && is_root && cmd.find_b && (ra_r != x_r)) begin
      parent_mem[ra_r] <= x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      ncnt_r      <= NODE_LIMIT;
      loaded_r    <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
      src_sel_r   <= 1'b0;
      i_r         <= '0;
    end else begin
      if (cfg_valid) ncnt_r <= cfg_node_count;
      if (cmd.par_clr) clr_r <= clr_r + NODE_W'(1);
      if (load_wr) loaded_r <= loaded_r + LW'(1);
      if (cmd.load_en && (bad || full)) err_r <= 1'b1;
      if (cmd.sort_init) begin
        src_sel_r <= 1'b0;
        i_r       <= '0;
      end
      if (cmd.merge_wr && pass_end) src_sel_r <= !src_sel_r;
      if (cmd.find_step && is_root && cmd.find_b) i_r <= i_r + LW'(1);
      if (cmd.result) begin
        out_valid_r <= 1'b1;
        loaded_r    <= '0;
        err_r       <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // merge pointers, union-find walk, accumulator
  always_ff @(posedge clk) begin
    if (cmd.result) out_data_r <= out_t'{sum_r, err_r};
    if (cmd.sort_init) begin
      width_r <= CW'(1);
      l_r     <= '0;
      le_r    <= le_init;
      r_r     <= le_init;
      re_r    <= re_init;
      k_r     <= '0;
      sum_r   <= '0;
    end
    if (cmd.merge_wr) begin
      if (pass_end) begin
        width_r <= width2;
        l_r     <= '0;
        le_r    <= le_pass;
        r_r     <= le_pass;
        re_r    <= re_pass;
        k_r     <= '0;
      end else if (run_end) begin
        l_r  <= re_r;
        le_r <= le_run;
        r_r  <= le_run;
        re_r <= re_run;
        k_r  <= k_r + CW'(1);
      end else begin
        l_r <= l_s;
        r_r <= r_s;
        k_r <= k_r + CW'(1);
      end
    end
    if (cmd.edge_latch) begin
      edge_r <= src0;
      x_r    <= src0.node_a;
    end
    if (cmd.find_step) begin
      if (!is_root) begin
        x_r <= par;
      end else if (!cmd.find_b) begin
        ra_r <= x_r;
        x_r  <= edge_r.node_b;
      end else if (ra_r != x_r) begin
        sum_r <= sum_r + TOTAL_W'(edge_r.weight);
      end
    end
  end

endmodule

>>> src/min_spanning_forest_weight_top.sv
// sequence: one edge per cycle while loading; after the last edge a clear of the parent table,
// a setup step, ceil(log2 n) merge passes over the stored edges, then per stored edge a
// union-find walk over the parents of both endpoints, an end check, then the result
// no new graph is accepted before the result is registered: input stalls from the last edge until the
// result is registered, longer while a previous result is still held
// reset: rst_n synchronous active low; parent table rebuilt by a clear of all 1024 entries each graph
// ----------------------------------------------------------------------------
// min_spanning_forest_weight_top
// kruskal minimum spanning forest weight over loaded edges
// ----------------------------------------------------------------------------
module min_spanning_forest_weight_top #(
  parameter int MAX_EDGES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  msfw_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output msfw_pkg::out_t              out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [msfw_pkg::NCNT_W-1:0] cfg_node_count
);
  import msfw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  msfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_edge),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  msfw_dp #(
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data        (in_data),
    .cfg_valid      (cfg_valid),
    .cfg_node_count (cfg_node_count),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_data       (out_data)
  );

endmodule
